>>> hdl/plt_pkg.sv
`default_nettype none

package plt_pkg;

  // list geometry
  localparam int CAPACITY      = 64;
  localparam int ELEMENT_WIDTH = 32;
  localparam int IDX_W         = $clog2(CAPACITY);
  localparam int CNT_W         = $clog2(CAPACITY + 1);

  // word field widths
  localparam int MODE_W   = 3;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic [MODE_W-1:0] M_GET   = 3'd0;
  localparam logic [MODE_W-1:0] M_SET   = 3'd1;
  localparam logic [MODE_W-1:0] M_INS   = 3'd2;
  localparam logic [MODE_W-1:0] M_ERASE = 3'd3;
  localparam logic [MODE_W-1:0] M_PUSH  = 3'd4;
  localparam logic [MODE_W-1:0] M_POP   = 3'd5;
  localparam logic [MODE_W-1:0] M_FIND  = 3'd6;
  localparam logic [MODE_W-1:0] M_CLEAR = 3'd7;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  // cell update codes
  localparam logic [1:0] CELL_HOLD       = 2'd0;
  localparam logic [1:0] CELL_WRITE      = 2'd1;
  localparam logic [1:0] CELL_SHIFT_UP   = 2'd2;
  localparam logic [1:0] CELL_SHIFT_DOWN = 2'd3;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                     capture;
    logic [1:0]               op;
    logic [POS_W-1:0]         pos;
    logic [POS_W-1:0]         rd_pos;
    logic [CNT_W-1:0]         count;
    logic [ELEMENT_WIDTH-1:0] elem;
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> hdl/plt_req_if.sv
`default_nettype none

interface plt_req_if;
  logic                                valid;
  logic                                ready;
  logic [plt_pkg::MODE_W-1:0]          mode;
  logic [plt_pkg::POS_W-1:0]           position;
  logic [plt_pkg::ELEMENT_WIDTH-1:0]   element;

  modport source (output valid, mode, position, element, input ready);
  modport sink   (input valid, mode, position, element, output ready);
endinterface

`default_nettype wire

>>> hdl/plt_rsp_if.sv
`default_nettype none

interface plt_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [plt_pkg::ELEMENT_WIDTH-1:0]   value;
  logic                                found;
  logic [plt_pkg::IDX_W-1:0]           found_index;
  logic [plt_pkg::CNT_W-1:0]           count;
  logic [plt_pkg::STATUS_W-1:0]        status;

  modport source (output valid, value, found, found_index, count, status, input ready);
  modport sink   (input valid, value, found, found_index, count, status, output ready);
endinterface

`default_nettype wire

>>> hdl/plt_cell.sv
`default_nettype none

module plt_cell (
  input  wire logic                                clk,
  input  wire logic [plt_pkg::IDX_W-1:0]           index,
  input  wire plt_pkg::cell_cmd_t                  cmd,
  input  wire logic [plt_pkg::ELEMENT_WIDTH-1:0]   prev_data,
  input  wire logic [plt_pkg::ELEMENT_WIDTH-1:0]   next_data,
  output logic      [plt_pkg::ELEMENT_WIDTH-1:0]   data,
  output logic      [plt_pkg::ELEMENT_WIDTH-1:0]   rd_word,
  output logic                                     match
);

  logic [plt_pkg::POS_W-1:0] my_pos;
  logic [plt_pkg::CNT_W-1:0] my_cnt;

  assign my_pos = plt_pkg::POS_W'(index);
  assign my_cnt = plt_pkg::CNT_W'(index);

  // read and compare see the contents before this word's update
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_word <= (my_pos == cmd.rd_pos) ? data : '0;
      match   <= (my_cnt < cmd.count) && (data == cmd.elem);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      plt_pkg::CELL_WRITE: begin
        if (my_pos == cmd.pos) data <= cmd.elem;
      end
      plt_pkg::CELL_SHIFT_UP: begin
        if (my_pos == cmd.pos) data <= cmd.elem;
        else if (my_pos > cmd.pos) data <= prev_data;
      end
      plt_pkg::CELL_SHIFT_DOWN: begin
        if (my_pos >= cmd.pos) data <= next_data;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/positional_list_table_top.sv
`default_nettype none

// channel  dir  fields                                      accepted when
// -------  ---  ------------------------------------------  -------------------
// req      in   mode, position, element                     req.valid & req.ready
// rsp      out  value, found, found_index, count, status    rsp.valid & rsp.ready
//
// each word: the accept edge updates the cell row and latches every cell's read
// word and match flag; once the output register is free, S_EVAL merges them
// (or-reduce for the read, lowest-set-bit isolate for find) into the output reg
// one word in flight at a time; the next word is taken once the previous
// result sits in the output register, even while rsp is stalled
// reset (rst, synchronous) empties the list; cells are not cleared, only read below count

module positional_list_table_top (
  input  wire logic clk,
  input  wire logic rst,
  plt_req_if.sink   req,
  plt_rsp_if.source rsp
);

  localparam int CAP = plt_pkg::CAPACITY;
  localparam int EW  = plt_pkg::ELEMENT_WIDTH;

  // controller states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EVAL = 1'b1;

  logic                          state;
  logic [plt_pkg::CNT_W-1:0]     count;
  logic [plt_pkg::CNT_W-1:0]     count_next;
  logic [plt_pkg::STATUS_W-1:0]  status_next;

  // pending word bookkeeping
  logic                          p_read;
  logic                          p_find;
  logic [plt_pkg::STATUS_W-1:0]  p_status;
  logic [plt_pkg::CNT_W-1:0]     p_count;

  // output register
  logic                          out_valid;
  logic [EW-1:0]                 out_value;
  logic                          out_found;
  logic [plt_pkg::IDX_W-1:0]     out_index;
  logic [plt_pkg::CNT_W-1:0]     out_count;
  logic [plt_pkg::STATUS_W-1:0]  out_status;

  logic                          accept;
  logic                          load;
  logic                          op_ok;
  logic                          is_read;
  plt_pkg::cell_cmd_t            cmd;

  logic [EW-1:0]                 cell_data  [CAP];
  logic [EW-1:0]                 cell_rd    [CAP];
  logic [CAP-1:0]                cell_match;

  logic [EW-1:0]                 rd_merge;
  logic [CAP-1:0]                first_hit;
  logic [plt_pkg::IDX_W-1:0]     hit_index;

  logic [plt_pkg::CNT_W-1:0]     pos_c;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign load      = (state == S_EVAL) && (!out_valid || rsp.ready);
  assign pos_c     = plt_pkg::CNT_W'(req.position);

  // status and count after the operation, from the current count
  always_comb begin
    status_next = plt_pkg::ST_OK;
    count_next  = count;
    case (req.mode)
      plt_pkg::M_GET, plt_pkg::M_SET, plt_pkg::M_ERASE: begin
        if (count == '0) status_next = plt_pkg::ST_EMPTY;
        else if (pos_c >= count) status_next = plt_pkg::ST_BAD_POS;
        else if (req.mode == plt_pkg::M_ERASE) count_next = count - 1'b1;
      end
      plt_pkg::M_INS: begin
        if (pos_c > count) status_next = plt_pkg::ST_BAD_POS;
        else if (count >= plt_pkg::CNT_W'(CAP)) status_next = plt_pkg::ST_FULL;
        else count_next = count + 1'b1;
      end
      plt_pkg::M_PUSH: begin
        if (count >= plt_pkg::CNT_W'(CAP)) status_next = plt_pkg::ST_FULL;
        else count_next = count + 1'b1;
      end
      plt_pkg::M_POP: begin
        if (count == '0) status_next = plt_pkg::ST_EMPTY;
        else count_next = count - 1'b1;
      end
      plt_pkg::M_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign op_ok   = (status_next == plt_pkg::ST_OK);
  assign is_read = op_ok && ((req.mode == plt_pkg::M_GET) || (req.mode == plt_pkg::M_POP));

  // broadcast to the cell row; a failed operation leaves every cell alone
  always_comb begin
    cmd.capture = accept;
    cmd.op      = plt_pkg::CELL_HOLD;
    cmd.pos     = req.position;
    cmd.rd_pos  = req.position;
    cmd.count   = count;
    cmd.elem    = req.element;
    if (req.mode == plt_pkg::M_POP) cmd.rd_pos = plt_pkg::POS_W'(count - 1'b1);
    if (accept && op_ok) begin
      case (req.mode)
        plt_pkg::M_SET:   cmd.op = plt_pkg::CELL_WRITE;
        plt_pkg::M_INS:   cmd.op = plt_pkg::CELL_SHIFT_UP;
        plt_pkg::M_ERASE: cmd.op = plt_pkg::CELL_SHIFT_DOWN;
        plt_pkg::M_PUSH: begin
          cmd.op  = plt_pkg::CELL_WRITE;
          cmd.pos = plt_pkg::POS_W'(count);
        end
        default: cmd.op = plt_pkg::CELL_HOLD;
      endcase
    end
  end

  // the row of cells, each wired to its neighbors
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic [EW-1:0] prev_w;
    logic [EW-1:0] next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_prev
      assign prev_w = cell_data[i-1];
    end
    if (i == CAP - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_next
      assign next_w = cell_data[i+1];
    end
    plt_cell u_cell (
      .clk       (clk),
      .index     (plt_pkg::IDX_W'(i)),
      .cmd       (cmd),
      .prev_data (prev_w),
      .next_data (next_w),
      .data      (cell_data[i]),
      .rd_word   (cell_rd[i]),
      .match     (cell_match[i])
    );
  end

  // only the addressed cell can latch a nonzero read word
  always_comb begin
    rd_merge = '0;
    for (int i = 0; i < CAP; i++) rd_merge = rd_merge | cell_rd[i];
  end

  // isolate the lowest matching cell, then encode its one-hot position
  assign first_hit = cell_match & (~cell_match + 1'b1);

  always_comb begin
    hit_index = '0;
    for (int i = 0; i < CAP; i++) begin
      if (first_hit[i]) hit_index = hit_index | plt_pkg::IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      if (accept) begin
        state <= S_EVAL;
        count <= count_next;
      end else if (load) begin
        state <= S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_read   <= is_read;
      p_find   <= (req.mode == plt_pkg::M_FIND);
      p_status <= status_next;
      p_count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_value  <= p_read ? rd_merge : '0;
      out_found  <= p_find && (|cell_match);
      out_index  <= p_find ? hit_index : '0;
      out_count  <= p_count;
      out_status <= p_status;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.value       = out_value;
  assign rsp.found       = out_found;
  assign rsp.found_index = out_index;
  assign rsp.count       = out_count;
  assign rsp.status      = out_status;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= plt_pkg::CNT_W'(CAP))
    else $error("entry count above capacity");

  a_error_keeps_count: assert property (@(posedge clk) disable iff (rst)
    accept && !op_ok |=> count == $past(count))
    else $error("failed operation changed the count");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready && state == S_EVAL)
    else $error("second word taken while one is pending");

  a_found_only_ok: assert property (@(posedge clk) disable iff (rst)
    load && p_find |=> out_status == plt_pkg::ST_OK)
    else $error("find reported a nonzero status");
`endif

endmodule

`default_nettype wire

>>> dv/positional_list_table_top_tb.sv
module positional_list_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plt_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 7;
  // random words after the opening table
  localparam int RANDOM_WORDS = 550;
  // last stretch of the run is driven back to back on both sides
  localparam int QUIET_TAIL   = 80;
  // receiver hold-off long enough to back the block up into req
  localparam int LONG_HOLD    = 200;
  // cycles with no word moving on either channel before giving up
  localparam int STUCK_LIMIT  = 2000;
  // drain margin after the last reply
  localparam int SETTLE_CYCLES = 8;

  // one reply word as the block presents it
  typedef struct packed {
    logic [ELEMENT_WIDTH-1:0] value;
    logic                     found;
    logic [IDX_W-1:0]         found_index;
    logic [CNT_W-1:0]         count;
    logic [STATUS_W-1:0]      status;
  } list_reply_t;

  // opening table row: request plus, where pinned, the reply typed in by hand
  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         pos;
    logic [ELEMENT_WIDTH-1:0] elem;
    logic                     pinned;
    list_reply_t              reply;
  } plan_row_t;

  localparam int PLAN_ROWS = 25;

  // walk the corner cases from an empty list: empty errors first, then a
  // short list built with insert and push, range errors at and past the
  // count, duplicates for find, erase at both ends, clear and empty again
  plan_row_t opening_plan [PLAN_ROWS] = '{
    // empty list: empty wins over a bad position
    '{M_GET,   7'd0,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, 6'd0, 7'd0, ST_EMPTY}},
    '{M_SET,   7'd127, 32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, 6'd0, 7'd0, ST_EMPTY}},
    '{M_ERASE, 7'd64,  32'h0000_0000, 1'b1, '{32'h0, 1'b0, 6'd0, 7'd0, ST_EMPTY}},
    '{M_POP,   7'd0,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, 6'd0, 7'd0, ST_EMPTY}},
    '{M_FIND,  7'd0,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, 6'd0, 7'd0, ST_OK}},
    '{M_INS,   7'd1,   32'h0000_0001, 1'b1, '{32'h0, 1'b0, 6'd0, 7'd0, ST_BAD_POS}},
    // build [ffffffff, 0, aaaaaaaa]
    '{M_INS,   7'd0,   32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, 6'd0, 7'd1, ST_OK}},
    '{M_PUSH,  7'd0,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, 6'd0, 7'd2, ST_OK}},
    '{M_PUSH,  7'd0,   32'hAAAA_AAAA, 1'b1, '{32'h0, 1'b0, 6'd0, 7'd3, ST_OK}},
    // position equal to the count and far past it
    '{M_GET,   7'd3,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, 6'd0, 7'd3, ST_BAD_POS}},
    '{M_GET,   7'd127, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, 6'd0, 7'd3, ST_BAD_POS}},
    '{M_GET,   7'd0,   32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b0, 6'd0, 7'd3, ST_OK}},
    // insert at the count appends
    '{M_INS,   7'd3,   32'h5555_5555, 1'b1, '{32'h0, 1'b0, 6'd0, 7'd4, ST_OK}},
    '{M_INS,   7'd1,   32'h1234_5678, 1'b0, '0},
    '{M_SET,   7'd0,   32'h8000_0001, 1'b0, '0},
    // second zero so find must pick the lower index
    '{M_PUSH,  7'd99,  32'h0000_0000, 1'b0, '0},
    '{M_FIND,  7'd0,   32'h0000_0000, 1'b0, '0},
    '{M_FIND,  7'd0,   32'hDEAD_BEEF, 1'b0, '0},
    '{M_ERASE, 7'd0,   32'h0000_0000, 1'b0, '0},
    '{M_ERASE, 7'd4,   32'h0000_0000, 1'b0, '0},
    '{M_ERASE, 7'd4,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, 6'd0, 7'd4, ST_BAD_POS}},
    '{M_POP,   7'd0,   32'h0000_0000, 1'b0, '0},
    '{M_SET,   7'd3,   32'h0F0F_0F0F, 1'b1, '{32'h0, 1'b0, 6'd0, 7'd3, ST_BAD_POS}},
    '{M_CLEAR, 7'd0,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, 6'd0, 7'd0, ST_OK}},
    '{M_GET,   7'd0,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, 6'd0, 7'd0, ST_EMPTY}}
  };

  logic clk = 1'b0;
  logic rst;

  plt_req_if req_bus ();
  plt_rsp_if rsp_bus ();

  positional_list_table_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predicted list contents, advanced once per accepted req word
  logic [ELEMENT_WIDTH-1:0] list_cells [CAPACITY];
  int                       list_len = 0;

  // replies still owed by the block, oldest first
  list_reply_t replies_due [$];

  int  words_sent    = 0;
  int  hold_requests = 0;
  bit  src_jitter    = 1'b0;
  bit  sink_jitter   = 1'b0;
  bit  failed        = 1'b0;

  // apply one list operation to the predicted contents and return its reply
  function automatic list_reply_t apply_list_op(input logic [MODE_W-1:0]        mode,
                                                input logic [POS_W-1:0]         pos,
                                                input logic [ELEMENT_WIDTH-1:0] elem);
    list_reply_t r;
    int          n;
    int          p;
    int          i;
    r = '0;
    n = list_len;
    p = int'(pos);
    case (mode)
      M_GET, M_SET, M_ERASE: begin
        // empty is reported ahead of a bad position
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= n) begin
          r.status = ST_BAD_POS;
        end else if (mode == M_GET) begin
          r.value = list_cells[p];
        end else if (mode == M_SET) begin
          list_cells[p] = elem;
        end else begin
          for (i = p + 1; i < n; i++) list_cells[i - 1] = list_cells[i];
          list_len = n - 1;
        end
      end
      M_INS: begin
        // range is checked before fullness
        if (p > n) begin
          r.status = ST_BAD_POS;
        end else if (n >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = n; i > p; i--) list_cells[i] = list_cells[i - 1];
          list_cells[p] = elem;
          list_len = n + 1;
        end
      end
      M_PUSH: begin
        if (n >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_cells[n] = elem;
          list_len = n + 1;
        end
      end
      M_POP: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = list_cells[n - 1];
          list_len = n - 1;
        end
      end
      M_FIND: begin
        // lowest matching index wins, a miss still reports ok
        for (i = 0; i < n; i++) begin
          if (list_cells[i] == elem) begin
            r.found       = 1'b1;
            r.found_index = IDX_W'(i);
            break;
          end
        end
      end
      default: begin
        // clear: cells keep their words but drop out of reach
        list_len = 0;
      end
    endcase
    r.count = CNT_W'(list_len);
    return r;
  endfunction

  // element choice: often a word already in the list so find hits and
  // duplicates build up, sometimes all zeros or all ones
  function automatic logic [ELEMENT_WIDTH-1:0] pick_element();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3, 4: begin
        if (list_len != 0) return list_cells[$urandom_range(0, list_len - 1)];
      end
      default: ;
    endcase
    return ELEMENT_WIDTH'($urandom());
  endfunction

  // hold a req word until the block takes it, then book its reply
  task automatic offer_word(input logic [MODE_W-1:0]        mode,
                            input logic [POS_W-1:0]         pos,
                            input logic [ELEMENT_WIDTH-1:0] elem,
                            input logic                     pinned = 1'b0,
                            input list_reply_t              pin_reply = '0);
    list_reply_t predicted;
    req_bus.valid    <= 1'b1;
    req_bus.mode     <= mode;
    req_bus.position <= pos;
    req_bus.element  <= elem;
    @(posedge clk);
    while (req_bus.ready !== 1'b1) @(posedge clk);
    // accepted at this edge; the predictor moves even for pinned rows
    predicted = apply_list_op(mode, pos, elem);
    replies_due.push_back(pinned ? pin_reply : predicted);
    words_sent++;
    // valid stays up into the next word unless a gap is drawn here
    if (src_jitter && $urandom_range(0, 5) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // sender pause until the block has handed back everything
  task automatic wait_for_replies();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // mixed traffic with mostly in-range positions
  task automatic churn(input int words);
    int                n;
    int                r;
    int                p;
    logic [MODE_W-1:0] mode;
    for (n = 0; n < words; n++) begin
      r = $urandom_range(0, 31);
      if (r < 5)       mode = M_GET;
      else if (r < 9)  mode = M_SET;
      else if (r < 14) mode = M_INS;
      else if (r < 18) mode = M_ERASE;
      else if (r < 23) mode = M_PUSH;
      else if (r < 27) mode = M_POP;
      else if (r < 31) mode = M_FIND;
      else             mode = M_CLEAR;
      // one in eight positions anywhere in the field, errors included
      if ($urandom_range(0, 7) == 0)  p = $urandom_range(0, (1 << POS_W) - 1);
      else if (mode == M_INS)         p = $urandom_range(0, list_len);
      else if (list_len != 0)         p = $urandom_range(0, list_len - 1);
      else                            p = 0;
      offer_word(mode, POS_W'(p), pick_element());
    end
  endtask

  // grow to capacity, then poke at the full list and its last cell
  task automatic fill_to_capacity();
    logic [ELEMENT_WIDTH-1:0] probe;
    while (list_len < CAPACITY) begin
      if ($urandom_range(0, 1) == 0) begin
        offer_word(M_PUSH, POS_W'($urandom_range(0, (1 << POS_W) - 1)), pick_element());
      end else begin
        offer_word(M_INS, POS_W'($urandom_range(0, list_len)), pick_element());
      end
    end
    offer_word(M_PUSH, POS_W'(0), pick_element());
    // insert at the count on a full list is full, one past it is bad position
    offer_word(M_INS, POS_W'(CAPACITY), pick_element());
    offer_word(M_INS, POS_W'(CAPACITY + 1), pick_element());
    offer_word(M_INS, POS_W'($urandom_range(0, CAPACITY - 1)), pick_element());
    offer_word(M_GET, POS_W'(CAPACITY - 1), '0);
    offer_word(M_GET, POS_W'(CAPACITY), '0);
    probe = ELEMENT_WIDTH'($urandom());
    offer_word(M_SET, POS_W'(CAPACITY - 1), probe);
    offer_word(M_FIND, POS_W'(0), probe);
    offer_word(M_FIND, POS_W'(0), list_cells[0]);
    offer_word(M_ERASE, POS_W'($urandom_range(0, CAPACITY - 1)), '0);
  endtask

  // pop down to nothing, then the empty-list errors
  task automatic drain_list();
    while (list_len != 0) begin
      offer_word(M_POP, POS_W'($urandom_range(0, (1 << POS_W) - 1)), pick_element());
    end
    offer_word(M_POP, POS_W'(0), '0);
    offer_word(M_GET, POS_W'($urandom_range(0, (1 << POS_W) - 1)), '0);
    offer_word(M_ERASE, POS_W'(0), '0);
    offer_word(M_FIND, POS_W'(0), pick_element());
  endtask

  // anything the fields can carry
  task automatic noise(input int words);
    int n;
    for (n = 0; n < words; n++) begin
      offer_word(MODE_W'($urandom_range(0, 7)),
                 POS_W'($urandom_range(0, (1 << POS_W) - 1)),
                 ELEMENT_WIDTH'($urandom()));
    end
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("[%0t] %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      failed = 1'b1;
    end
  endtask

  // stimulus: reset, opening table, long receiver hold-off, then episodes
  initial begin : stimulus
    int k;
    int pick;
    rst              <= 1'b1;
    req_bus.valid    <= 1'b0;
    req_bus.mode     <= M_GET;
    req_bus.position <= '0;
    req_bus.element  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // opening table with gaps on both sides
    src_jitter  = 1'b1;
    sink_jitter = 1'b1;
    for (k = 0; k < PLAN_ROWS; k++) begin
      offer_word(opening_plan[k].mode, opening_plan[k].pos, opening_plan[k].elem,
                 opening_plan[k].pinned, opening_plan[k].reply);
    end
    wait_for_replies();

    // receiver sits on its ready while req keeps coming back to back,
    // so the output register and the word in flight back up into req
    src_jitter = 1'b0;
    hold_requests++;
    churn(24);
    wait_for_replies();

    // first episode always reaches the full list
    src_jitter = 1'b1;
    fill_to_capacity();

    while (words_sent < PLAN_ROWS + RANDOM_WORDS) begin
      if (words_sent >= PLAN_ROWS + RANDOM_WORDS - QUIET_TAIL) begin
        src_jitter  = 1'b0;
        sink_jitter = 1'b0;
      end else begin
        // some episodes run with no gaps at all
        src_jitter  = ($urandom_range(0, 3) != 0);
        sink_jitter = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 9);
      if (pick < 6)       churn($urandom_range(25, 40));
      else if (pick == 6) fill_to_capacity();
      else if (pick == 7) drain_list();
      else                noise(8);
      if ($urandom_range(0, 4) == 0) wait_for_replies();
    end

    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failed) begin
      $display("Regression FAIL");
    end else begin
      $display("Regression PASS");
    end
    $finish;
  end

  // rsp ready: random stall bursts, plus the long hold-off
  initial begin : reply_sink
    int unsigned sink_wait;
    int          hold_served;
    sink_wait   = 0;
    hold_served = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        sink_wait   = LONG_HOLD;
      end
      if (sink_wait != 0) begin
        sink_wait--;
        rsp_bus.ready <= 1'b0;
      end else if (sink_jitter && $urandom_range(0, 5) == 0) begin
        // low this cycle, with the rest of the stall counted in sink_wait
        sink_wait = $urandom_range(0, 9);
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // compare every accepted rsp word with the oldest booked reply
  initial begin : reply_checker
    list_reply_t want;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
        if (replies_due.size() == 0) begin
          $display("[%0t] unexpected reply: expected none, actual value %0h count %0d status %0d",
                   $time, rsp_bus.value, rsp_bus.count, rsp_bus.status);
          failed = 1'b1;
        end else begin
          want = replies_due.pop_front();
          check_field("value",       64'(want.value),       64'(rsp_bus.value));
          check_field("found",       64'(want.found),       64'(rsp_bus.found));
          check_field("found_index", 64'(want.found_index), 64'(rsp_bus.found_index));
          check_field("count",       64'(want.count),       64'(rsp_bus.count));
          check_field("status",      64'(want.status),      64'(rsp_bus.status));
        end
      end
    end
  end

  // watchdog: consecutive cycles with no word moving on either channel
  initial begin : watchdog
    int stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk);
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
    end
    $display("[%0t] timeout: no word moved for %0d cycles, %0d replies outstanding",
             $time, STUCK_LIMIT, replies_due.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
